>>> src/hble_pkg.sv
// Package: shared types, constants and helpers for the hexamer bias length engine.
`timescale 1ns / 1ps
`default_nettype none
package hble_pkg;
  localparam int TABLE_ENTRIES_DEF  = 4096;
  localparam int EXPECTED_WIDTH_DEF = 48;
  localparam int CODE_W             = 12;
  localparam int LEN_W              = 48;
  localparam int OBS_TOTAL_W        = 44;
  localparam int IN_DATA_W          = 88;
  localparam int QUEUE_DEPTH        = 4;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ACCUM = 2'd1,
    REQ_EVAL  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  localparam logic [1:0] CFG_STRAND = 2'd0;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    req_t              req;
    logic [CODE_W-1:0] code;
    logic [31:0]       value;
    logic              active;
    logic              last;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_WAIT,
    ST_APPLY,
    ST_DIV,
    ST_SUM,
    ST_MUL,
    ST_FDIV,
    ST_OUT
  } st_t;

  // 2-bit nucleotide value in bits [1:0]; invalid characters report ok (bit 2) = 0.
  function automatic logic [2:0] base_value(input logic [7:0] ch);
    logic [7:0] u;
    u = ch & 8'hDF;
    case (u)
      8'h41:   base_value = 3'b100;
      8'h43:   base_value = 3'b101;
      8'h47:   base_value = 3'b110;
      8'h54:   base_value = 3'b111;
      default: base_value = 3'b000;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> src/hble_front.sv
// Front part: rolls the hexamer code and classifies items into commands.
`timescale 1ns / 1ps
`default_nettype none
module hble_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire [1:0]              req_type,
  input  wire [11:0]             table_index,
  input  wire [31:0]             observed_count,
  input  wire [7:0]              base,
  input  wire                    reverse,
  input  wire                    restart,
  input  wire                    counted,
  input  wire [31:0]             weight,
  input  wire                    last,
  output hble_pkg::cmd_t         cmd,
  output logic                   cmd_valid,
  input  wire                    cmd_full
);
  import hble_pkg::*;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [2:0]        fill_r, fill_nxt;
  logic [2:0]        bv;
  logic [1:0]        v;
  logic [CODE_W-1:0] c0;
  logic [2:0]        f0;

  assign in_ready  = !cmd_full;
  assign cmd_valid = in_valid && in_ready;

  always_comb begin
    bv       = base_value(base);
    c0       = restart ? '0 : code_r;
    f0       = restart ? '0 : fill_r;
    code_nxt = code_r;
    fill_nxt = fill_r;
    if (!reverse) begin
      v        = bv[2] ? bv[1:0] : 2'd0;
      code_nxt = {c0[9:0], v};
    end else begin
      v        = bv[2] ? ~bv[1:0] : 2'd0;
      code_nxt = {v, c0[11:2]};
    end
    fill_nxt = (f0 < 3'd6) ? f0 + 3'd1 : f0;
    cmd.req    = req_t'(req_type);
    cmd.code   = (req_type == REQ_LOAD) ? table_index : code_nxt;
    cmd.value  = (req_type == REQ_LOAD) ? observed_count : weight;
    cmd.active = counted && (fill_nxt == 3'd6);
    cmd.last   = last;
    if (req_type == REQ_EVAL) cmd.last = last;
    // restart flag of an evaluate pass rides in value bit 0
    if (req_type == REQ_EVAL) cmd.value = {31'd0, restart};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
      fill_r <= '0;
    end else if (cmd_valid &&
                 (req_type == REQ_ACCUM || req_type == REQ_EVAL)) begin
      code_r <= code_nxt;
      fill_r <= fill_nxt;
    end
  end
endmodule
`default_nettype wire

>>> src/hble_queue.sv
// Short command queue between front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module hble_queue #(
  parameter int DEPTH = hble_pkg::QUEUE_DEPTH
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             wr_en,
  input  hble_pkg::cmd_t  wr_data,
  output logic            full,
  output logic            empty,
  input  wire             rd_en,
  output hble_pkg::cmd_t  rd_data
);
  import hble_pkg::*;
  localparam int AW = $clog2(DEPTH);
  cmd_t           mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule
`default_nettype wire

>>> src/hble_back.sv
// Back part: table read-modify-write, ratio division and final scaling.
`timescale 1ns / 1ps
`default_nettype none
module hble_back #(
  parameter int TABLE_ENTRIES  = hble_pkg::TABLE_ENTRIES_DEF,
  parameter int EXPECTED_WIDTH = hble_pkg::EXPECTED_WIDTH_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        strand_sel,
  input  hble_pkg::cmd_t             cmd,
  input  wire                        cmd_empty,
  output logic                       cmd_pop,
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic [hble_pkg::LEN_W-1:0] out_tdata,
  output logic                       out_tuser
);
  import hble_pkg::*;
  localparam int AW  = $clog2(TABLE_ENTRIES);
  localparam int EW  = EXPECTED_WIDTH;
  localparam int TW  = (EW + 12 > 64) ? 64 : EW + 12;
  localparam logic [EW-1:0] EMAX = {EW{1'b1}};
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  logic [31:0]   obs_mem [TABLE_ENTRIES];
  logic [EW-1:0] exp_mem [TABLE_ENTRIES];
  logic [31:0]   obs_rd_r;
  logic [EW-1:0] exp_rd_r;

  st_t st_r, st_nxt;
  cmd_t c_r;
  logic [AW:0]            clr_cnt_r;
  logic                   clr_last;
  logic                   init_r;
  logic                   obs_we, exp_we;
  logic [EW-1:0]          exp_wd;
  logic [OBS_TOTAL_W-1:0] obs_tot_r;
  logic [TW-1:0]          exp_tot_r;
  logic [63:0]            rsum_r;
  logic                   sticky_r;
  logic [EW-1:0]          e_cur;
  // shared restoring divider
  logic [127:0]           dvd_r;
  logic [64:0]            rem_r;
  logic [63:0]            dvs_r;
  logic [6:0]             dcnt_r;
  logic                   over_r;
  logic [63:0]            q_r;
  // multiplier: 4 partial products of 32x32
  logic [1:0]             mcnt_r;
  logic [127:0]           prod_r;
  logic [LEN_W-1:0]       out_r;
  logic                   err_r;
  logic                   outv_r;
  logic                   out_load;
  logic [EW:0]            esum;
  logic [TW:0]            tsum;
  logic [64:0]            rs_add;
  logic [64:0]            rem_sh;
  logic [63:0]            a_part, b_part;
  logic [63:0]            pp;

  assign e_cur    = exp_rd_r;
  assign clr_last = (clr_cnt_r == (AW+1)'(TABLE_ENTRIES - 1));
  assign out_load = (st_r == ST_OUT) && (!outv_r || out_tready);

  // memories; the sweep after reset also zeroes the observed table
  always_ff @(posedge clk) begin
    if (st_r == ST_CLEAR) begin
      exp_mem[clr_cnt_r[AW-1:0]] <= '0;
      if (init_r) obs_mem[clr_cnt_r[AW-1:0]] <= '0;
    end else begin
      if (obs_we) obs_mem[c_r.code[AW-1:0]] <= c_r.value;
      if (exp_we) exp_mem[c_r.code[AW-1:0]] <= exp_wd;
    end
    obs_rd_r <= obs_mem[c_r.code[AW-1:0]];
    exp_rd_r <= exp_mem[c_r.code[AW-1:0]];
  end

  always_comb begin
    st_nxt  = st_r;
    cmd_pop = 1'b0;
    obs_we  = 1'b0;
    exp_we  = 1'b0;
    esum    = {1'b0, e_cur} + (EW+1)'(c_r.value);
    exp_wd  = esum[EW] ? EMAX : esum[EW-1:0];
    tsum    = {1'b0, exp_tot_r} + (TW+1)'(exp_wd - e_cur);
    rs_add  = {1'b0, rsum_r} + {1'b0, q_r};
    rem_sh  = {rem_r[63:0], dvd_r[127]};
    a_part  = mcnt_r[0] ? {32'd0, rsum_r[63:32]} : {32'd0, rsum_r[31:0]};
    b_part  = mcnt_r[1] ? 64'(exp_tot_r >> 32) : {32'd0, exp_tot_r[31:0]};
    pp      = a_part[31:0] * b_part[31:0];
    case (st_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          st_nxt  = ST_READ;
        end
      end
      ST_READ: st_nxt = ST_WAIT;
      ST_WAIT: begin
        case (c_r.req)
          REQ_LOAD:  st_nxt = ST_APPLY;
          REQ_CLEAR: st_nxt = ST_CLEAR;
          REQ_ACCUM: st_nxt = ST_APPLY;
          REQ_EVAL:  st_nxt = c_r.active ? ST_DIV : (c_r.last ? ST_MUL : ST_IDLE);
          default:   st_nxt = ST_IDLE;
        endcase
      end
      ST_APPLY: begin
        if (c_r.req == REQ_LOAD) obs_we = 1'b1;
        else if (c_r.active) exp_we = 1'b1;
        st_nxt = ST_IDLE;
      end
      ST_CLEAR: if (clr_last) st_nxt = ST_IDLE;
      ST_DIV:   if (dcnt_r == 7'd0) st_nxt = ST_SUM;
      ST_SUM:   st_nxt = c_r.last ? ST_MUL : ST_IDLE;
      ST_MUL:   if (mcnt_r == 2'd3) st_nxt = ST_FDIV;
      ST_FDIV:  if (dcnt_r == 7'd0) st_nxt = ST_OUT;
      ST_OUT:   st_nxt = out_load ? ST_IDLE : ST_OUT;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = outv_r;
  assign out_tdata  = out_r;
  assign out_tuser  = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      init_r    <= 1'b1;
      obs_tot_r <= '0;
      exp_tot_r <= '0;
      rsum_r    <= '0;
      sticky_r  <= 1'b0;
      outv_r    <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_load) outv_r <= 1'b1;
      else if (outv_r && out_tready) outv_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (cmd_pop) begin
            c_r <= cmd;
            if (cmd.req == REQ_EVAL && cmd.value[0]) rsum_r <= '0;
          end
          clr_cnt_r <= '0;
        end
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          exp_tot_r <= '0;
          sticky_r  <= 1'b0;
          if (clr_last) init_r <= 1'b0;
        end
        ST_WAIT: begin
          if (c_r.req == REQ_EVAL && c_r.active) begin
            if (e_cur == '0) begin
              q_r      <= '1;
              sticky_r <= 1'b1;
              dcnt_r   <= '0;
            end else begin
              dvd_r  <= {obs_rd_r, 96'd0};
              dvs_r  <= 64'(e_cur);
              rem_r  <= '0;
              q_r    <= '0;
              dcnt_r <= 7'd64;
            end
          end
          mcnt_r <= '0;
          prod_r <= '0;
        end
        ST_APPLY: begin
          if (c_r.req == REQ_LOAD)
            obs_tot_r <= obs_tot_r - OBS_TOTAL_W'(obs_rd_r) + OBS_TOTAL_W'(c_r.value);
          else if (c_r.active) begin
            if (esum[EW] || tsum[TW]) sticky_r <= 1'b1;
            exp_tot_r <= tsum[TW] ? TMAX : tsum[TW-1:0];
          end
        end
        ST_DIV: begin
          if (dcnt_r != 7'd0) begin
            dcnt_r <= dcnt_r - 1'b1;
            dvd_r  <= {dvd_r[126:0], 1'b0};
            if (rem_sh >= {1'b0, dvs_r}) begin
              rem_r <= rem_sh - {1'b0, dvs_r};
              q_r   <= {q_r[62:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              q_r   <= {q_r[62:0], 1'b0};
            end
          end
        end
        ST_SUM: begin
          if (rs_add[64]) begin
            rsum_r   <= '1;
            sticky_r <= 1'b1;
          end else rsum_r <= rs_add[63:0];
          mcnt_r <= '0;
          prod_r <= '0;
        end
        ST_MUL: begin
          prod_r <= prod_r + (128'(pp) << (32 * (32'(mcnt_r[0]) + 32'(mcnt_r[1]))));
          mcnt_r <= mcnt_r + 1'b1;
          if (mcnt_r == 2'd3) begin
            dvd_r  <= prod_r + (128'(pp) << 64);
            rem_r  <= '0;
            dvs_r  <= strand_sel ? 64'(obs_tot_r) << 16 : 64'(obs_tot_r) << 17;
            q_r    <= '0;
            over_r <= 1'b0;
            dcnt_r <= 7'd127;
          end
        end
        ST_FDIV: begin
          dvd_r <= {dvd_r[126:0], 1'b0};
          if (dcnt_r != 7'd0) dcnt_r <= dcnt_r - 1'b1;
          if (rem_sh >= {1'b0, dvs_r}) begin
            rem_r <= rem_sh - {1'b0, dvs_r};
            q_r   <= {q_r[62:0], 1'b1};
            if (dcnt_r >= 7'd48) over_r <= 1'b1;
          end else begin
            rem_r <= rem_sh;
            q_r   <= {q_r[62:0], 1'b0};
          end
        end
        ST_OUT: begin
          if (out_load) begin
            if (obs_tot_r == '0 || over_r) begin
              out_r <= {LEN_W{1'b1}};
              err_r <= 1'b1;
            end else begin
              out_r <= q_r[LEN_W-1:0];
              err_r <= sticky_r;
            end
            rsum_r   <= '0;
            sticky_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/hexamer_bias_length_engine.sv
// Top level of the hexamer bias length engine.
// Usage:
//   in_ channel: req_type in tuser, the other fields in tdata, last in tlast.
//   A front stage rolls the hexamer code and pushes a command into a 4-entry
//   queue; a back stage runs one command at a time against the observed and
//   expected tables (4096 entries each, one read and one write port).
//   Back stage work per item: load/accumulate read and update a table entry;
//   evaluate with a counted window runs a 64-step ratio divide; clear runs a
//   table sweep. The last base adds a multiply, a 128-step divide and an
//   output state before out_tvalid.
//   Items are processed one after another; the queue absorbs short bursts.
//   out_ channel gives one item per evaluate item with last set, held until
//   taken; the back stage keeps working and waits only when its next result
//   is ready before the previous one is taken. A full queue drops in_tready.
//   Reset (synchronous, rst_n low) empties the queue, zeroes the totals and
//   starts a sweep that zeroes both tables; items queue meanwhile.
//   cfg_ is an APB register port; register 0 selects strand-specific scaling.
`timescale 1ns / 1ps
`default_nettype none
module hexamer_bias_length_engine #(
  parameter int TABLE_ENTRIES  = hble_pkg::TABLE_ENTRIES_DEF,
  parameter int EXPECTED_WIDTH = hble_pkg::EXPECTED_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // table_index[11:0], observed_count[43:12], base[51:44], reverse[52],
  // restart[53], counted[54], weight[86:55], zero pad
  input  wire [hble_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  wire [1:0]                      in_tuser,
  input  wire                            in_tlast,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // scaled_length[47:0]
  output logic [hble_pkg::LEN_W-1:0]     out_tdata,
  // error_flag[0]
  output logic                           out_tuser,
  input  wire                            cfg_psel,
  input  wire                            cfg_penable,
  input  wire                            cfg_pwrite,
  input  wire [1:0]                      cfg_paddr,
  input  wire [31:0]                     cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import hble_pkg::*;
  logic strand_r;
  cmd_t fcmd, qcmd;
  logic fvalid, qfull, qempty, qpop;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_STRAND) ? {31'd0, strand_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) strand_r <= 1'b0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == CFG_STRAND)
      strand_r <= cfg_pwdata[0];
  end

  hble_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .req_type(in_tuser), .table_index(in_tdata[11:0]),
    .observed_count(in_tdata[43:12]), .base(in_tdata[51:44]),
    .reverse(in_tdata[52]), .restart(in_tdata[53]), .counted(in_tdata[54]),
    .weight(in_tdata[86:55]), .last(in_tlast),
    .cmd(fcmd), .cmd_valid(fvalid), .cmd_full(qfull)
  );

  hble_queue u_queue (
    .clk, .rst_n, .wr_en(fvalid), .wr_data(fcmd), .full(qfull),
    .empty(qempty), .rd_en(qpop), .rd_data(qcmd)
  );

  hble_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .EXPECTED_WIDTH(EXPECTED_WIDTH)) u_back (
    .clk, .rst_n, .strand_sel(strand_r), .cmd(qcmd), .cmd_empty(qempty),
    .cmd_pop(qpop), .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );
endmodule
`default_nettype wire

>>> src/hble_checker.sv
// Port-level checker for the hexamer bias length engine.
`timescale 1ns / 1ps
`default_nettype none
module hble_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [47:0] out_tdata,
  input wire        out_tuser,
  input wire        cfg_pready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result dropped under stall");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
  a_rdy: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
endmodule
bind hexamer_bias_length_engine hble_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser, .cfg_pready
);
`default_nettype wire
